FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define EEG_ASSERT_CLK(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block's own clock and reset.
`define EEG_ASSERT(lbl, prop, msg) \
	`EEG_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

FILE: sv/eeg_pkg.sv
// Package for the extended Euclid GCD block: defaults, widths and the
// command/status structs between controller and datapath. No dependencies.
package eeg_pkg;

	localparam int OPERAND_WIDTH_DEF = 31;
	localparam int COEFF_WIDTH       = 32;

	typedef struct packed {
		logic load;      // take a new operand pair, reset coefficients
		logic div_init;  // start a shift-subtract division of a0 by a1
		logic div_step;  // one quotient bit
		logic round_upd; // shift the remainder sequence by one round
		logic out_load;  // copy the finished result into the output register
	} eeg_cmd_t;

	typedef struct packed {
		logic a1_zero;   // current divisor is zero: sequence done
		logic div_last;  // the step in progress gives the last quotient bit
	} eeg_sts_t;

endpackage

FILE: sv/extended_euclid_gcd.sv
// Extended Euclid GCD: gcd(x, y) with Bezout coefficients s, t (s*x + t*y = gcd).
// For R remainder rounds between input transfer and m_tvalid, each round is one
// OPERAND_WIDTH-step shift-subtract division plus a check and an update. One item
// in work at a time; the next is taken while a result waits in the output register.
// Asynchronous active-low reset clears the controller and the output valid.
module extended_euclid_gcd #(
	parameter int OPERAND_WIDTH = eeg_pkg::OPERAND_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// [OPERAND_WIDTH-1:0] operand_x, [2*OPERAND_WIDTH-1:OPERAND_WIDTH] operand_y
	input  logic [((2*OPERAND_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// divisor (OPERAND_WIDTH), coeff_x (32), coeff_y (32), from the lowest bit up
	output logic [((OPERAND_WIDTH+2*eeg_pkg::COEFF_WIDTH+7)/8)*8-1:0] m_tdata
);

	localparam int W      = OPERAND_WIDTH;
	localparam int CW     = eeg_pkg::COEFF_WIDTH;
	localparam int OUT_W  = ((W + 2*CW + 7) / 8) * 8;

	eeg_pkg::eeg_cmd_t cmd;
	eeg_pkg::eeg_sts_t sts;
	logic [W-1:0]      divisor;
	logic [CW-1:0]     coeff_x, coeff_y;
	logic [OUT_W-1:0]  out_word;

	eeg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	eeg_dp #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_dp (
		.clk       (clk),
		.operand_x (s_tdata[W-1:0]),
		.operand_y (s_tdata[2*W-1:W]),
		.cmd       (cmd),
		.sts       (sts),
		.divisor   (divisor),
		.coeff_x   (coeff_x),
		.coeff_y   (coeff_y)
	);

	// zero-extend the packed fields to whole bytes
	assign out_word = OUT_W'({coeff_y, coeff_x, divisor});
	assign m_tdata  = out_word;

endmodule

FILE: sv/eeg_ctrl.sv
// Controller state machine for the extended Euclid GCD block.
// Depends on eeg_pkg; drives eeg_dp through eeg_cmd_t / eeg_sts_t.
module eeg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output eeg_pkg::eeg_cmd_t cmd,
	input  eeg_pkg::eeg_sts_t sts
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CHECK  = 5'b00010,
		ST_DIV    = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.a1_zero) begin
					state_d = ST_FINISH;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.round_upd = 1'b1;
				state_d       = ST_CHECK;
			end
			ST_FINISH: begin
				// hold the result until the output register frees up
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/eeg_dp.sv
// Datapath for the extended Euclid GCD block: remainder sequence, restoring
// divider with on-the-fly q*s and q*t accumulation, output register. Uses eeg_pkg.
module eeg_dp #(
	parameter int OPERAND_WIDTH = eeg_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic [OPERAND_WIDTH-1:0]        operand_x,
	input  logic [OPERAND_WIDTH-1:0]        operand_y,
	input  eeg_pkg::eeg_cmd_t               cmd,
	output eeg_pkg::eeg_sts_t               sts,
	output logic [OPERAND_WIDTH-1:0]        divisor,
	output logic [eeg_pkg::COEFF_WIDTH-1:0] coeff_x,
	output logic [eeg_pkg::COEFF_WIDTH-1:0] coeff_y
);

	localparam int W     = OPERAND_WIDTH;
	localparam int CW    = eeg_pkg::COEFF_WIDTH;
	localparam int CNT_W = $clog2(OPERAND_WIDTH);

	logic [W-1:0]     a0_q, a1_q, rem_q, dvd_q;
	logic [CW-1:0]    s0_q, s1_q, t0_q, t1_q, ps_q, pt_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     out_div_q;
	logic [CW-1:0]    out_cx_q, out_cy_q;

	logic [W:0]       shifted, diff;
	logic             qbit;
	logic [CW-1:0]    ps_next, pt_next;

	// One restoring division step; the quotient bit feeds both products.
	always_comb begin
		shifted = {rem_q, dvd_q[W-1]};
		diff    = shifted - {1'b0, a1_q};
		qbit    = !diff[W];
		ps_next = {ps_q[CW-2:0], 1'b0} + (qbit ? s1_q : '0);
		pt_next = {pt_q[CW-2:0], 1'b0} + (qbit ? t1_q : '0);
	end

	assign sts.a1_zero  = (a1_q == '0);
	assign sts.div_last = (cnt_q == CNT_W'(W - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a0_q <= operand_x;
			a1_q <= operand_y;
			s0_q <= CW'(1);
			s1_q <= '0;
			t0_q <= '0;
			t1_q <= CW'(1);
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			dvd_q <= a0_q;
			ps_q  <= '0;
			pt_q  <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= qbit ? diff[W-1:0] : shifted[W-1:0];
			dvd_q <= {dvd_q[W-2:0], 1'b0};
			ps_q  <= ps_next;
			pt_q  <= pt_next;
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.round_upd) begin
			a0_q <= a1_q;
			a1_q <= rem_q;
			s0_q <= s1_q;
			s1_q <= s0_q - ps_q;
			t0_q <= t1_q;
			t1_q <= t0_q - pt_q;
		end
		if (cmd.out_load) begin
			out_div_q <= a0_q;
			out_cx_q  <= s0_q;
			out_cy_q  <= t0_q;
		end
	end

	assign divisor = out_div_q;
	assign coeff_x = out_cx_q;
	assign coeff_y = out_cy_q;

endmodule

FILE: sv/eeg_checker.sv
// Port-level checker for extended_euclid_gcd, bound to the top level.
// Depends on eeg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module eeg_checker #(
	parameter int OPERAND_WIDTH = eeg_pkg::OPERAND_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [((2*OPERAND_WIDTH+7)/8)*8-1:0] s_tdata,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((OPERAND_WIDTH+2*eeg_pkg::COEFF_WIDTH+7)/8)*8-1:0] m_tdata
);

	logic       in_xfer, out_xfer;
	logic [1:0] pend_q;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	// track items taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_xfer && !in_xfer) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	`EEG_ASSERT(a_valid_hold, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped under stall")
	`EEG_ASSERT(a_data_hold, m_tvalid && !m_tready |=> $stable(m_tdata), "m_tdata changed under stall")
	`EEG_ASSERT(a_one_in_work, in_xfer |=> !s_tready, "second item taken while one is in work")
	`EEG_ASSERT(a_no_spurious, out_xfer |-> pend_q != 2'd0, "result without a pending item")
	`EEG_ASSERT(a_pend_bound, pend_q != 2'd3, "more than two items pending")

endmodule

bind extended_euclid_gcd eeg_checker #(
	.OPERAND_WIDTH (OPERAND_WIDTH)
) u_eeg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
